// File: hw/rtl/integer_partition_counter_unit_assert.svh
`ifndef INTEGER_PARTITION_COUNTER_UNIT_ASSERT_SVH
`define INTEGER_PARTITION_COUNTER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define IPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipc check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define IPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipc check failed");

`endif

// File: hw/rtl/ipc_pkg.sv
package ipc_pkg;

  // Width of a partition count; p(400) stays below 2^63.
  localparam int CNT_W = 63;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Per-cycle commands from the sequencer to the table datapath.
  typedef struct packed {
    logic clr;      // write a clear value this cycle
    logic clr_one;  // clear value is 1 (entry zero) instead of 0
    logic rd;       // issue one read-add-write step
  } tbl_ctrl_t;

endpackage

// File: hw/rtl/ipc_table.sv
module ipc_table #(
  parameter int MAX_N = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ipc_pkg::tbl_ctrl_t            ctrl,
  input  logic [$clog2(MAX_N+1)-1:0]    clr_addr,
  input  logic [$clog2(MAX_N+1)-1:0]    rd_hi,
  input  logic [$clog2(MAX_N+1)-1:0]    rd_lo,
  output logic [ipc_pkg::CNT_W-1:0]     sum,
  output logic                          sum_valid
);
  import ipc_pkg::*;

  localparam int AW    = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N + 1;

  logic [CNT_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] hi_q;
  logic [CNT_W-1:0] lo_q;
  logic [CNT_W-1:0] last_wd;
  logic [AW-1:0]    hi_addr;
  logic             hit_hi;
  logic             hit_lo;

  logic             we;
  logic [AW-1:0]    wa;
  logic [CNT_W-1:0] wd;
  logic [CNT_W-1:0] hi_eff;
  logic [CNT_W-1:0] lo_eff;

  // Forward the value written at the read edge; the array returns old data there.
  assign hi_eff = hit_hi ? last_wd : hi_q;
  assign lo_eff = hit_lo ? last_wd : lo_q;
  assign sum    = hi_eff + lo_eff;

  assign we = ctrl.clr | sum_valid;
  assign wa = ctrl.clr ? clr_addr : hi_addr;
  assign wd = ctrl.clr ? {{(CNT_W-1){1'b0}}, ctrl.clr_one} : sum;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctrl.rd) begin
      hi_q    <= mem[rd_hi];
      lo_q    <= mem[rd_lo];
      hi_addr <= rd_hi;
      hit_hi  <= we && (wa == rd_hi);
      hit_lo  <= we && (wa == rd_lo);
    end
    last_wd <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= ctrl.rd;
    end
  end

endmodule

// File: hw/rtl/integer_partition_counter_unit.sv
// Integer partition counter: returns p(n) for a cube count n.
// Input channel: in_valid / in_stall with cube_count (8 bits). A transfer
// happens at a rising edge with in_valid high and in_stall low; in_stall is
// high while a request is in work. Counts above MAX_N saturate to MAX_N, and
// a count of zero answers zero.
// Output channel: out_valid / out_stall with pyramid_count (63 bits). The
// result sits in an output register until the receiver takes it; a new
// request is accepted while that result still waits.
// Sequence: the table clears its n + 1 entries, then n(n+1)/2 read-add-write
// steps run at one per cycle through the single shared 63-bit adder, then a
// drain state lets the last write land and a finish state hands the result
// to the output register; a zero count goes straight to the finish state.
// A new request is taken only after the current one has left the finish
// state, so one request is in work at a time.
// The step rate is set by the table's single write port and its two
// registered read ports; same-edge write-read overlaps are forwarded.
// If the receiver stalls, the finished result waits and the block holds
// in_stall high until the output register frees up.
// Reset is synchronous (rst): it returns the sequencer to idle and drops
// out_valid. The table is not cleared at reset; each request rebuilds it.
module integer_partition_counter_unit #(
  parameter int MAX_N = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                cube_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ipc_pkg::CNT_W-1:0] pyramid_count
);
  import ipc_pkg::*;

  localparam int AW = $clog2(MAX_N + 1);

  state_t           state;
  state_t           state_next;

  logic [AW-1:0]    n_reg;
  logic [AW-1:0]    n_in;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    k_cnt;
  logic [AW-1:0]    m_cnt;
  logic [CNT_W-1:0] res;

  tbl_ctrl_t        ctrl;
  logic [AW-1:0]    rd_hi;
  logic [AW-1:0]    rd_lo;
  logic [CNT_W-1:0] sum;
  logic             sum_valid;
  logic             accept;
  logic             load_out;
  logic             last_step;

  // Saturate the requested count to the table size.
  always_comb begin
    if (32'(cube_count) > MAX_N) begin
      n_in = AW'(MAX_N);
    end else begin
      n_in = AW'(cube_count);
    end
  end

  assign accept    = in_valid && !in_stall;
  assign last_step = (m_cnt == n_reg) && (k_cnt == n_reg);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (n_in == '0) ? S_FINISH : S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (idx == n_reg) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl.clr     = (state == S_CLEAR);
    ctrl.clr_one = (idx == '0);
    ctrl.rd      = (state == S_RUN);
    rd_hi        = m_cnt;
    rd_lo        = m_cnt - k_cnt;
    in_stall     = (state != S_IDLE);
    load_out     = (state == S_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and the pending result; payload, so no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      n_reg <= n_in;
      res   <= '0;
    end
    unique case (state)
      S_IDLE: begin
        idx <= '0;
      end
      S_CLEAR: begin
        // Advance the clear pointer; prime the first step k = 1, m = 1.
        idx   <= idx + AW'(1);
        k_cnt <= AW'(1);
        m_cnt <= AW'(1);
      end
      S_RUN: begin
        if (m_cnt == n_reg) begin
          // Move to the next part size; its sweep starts at m = k.
          k_cnt <= k_cnt + AW'(1);
          m_cnt <= k_cnt + AW'(1);
        end else begin
          m_cnt <= m_cnt + AW'(1);
        end
      end
      S_DRAIN: begin
        // The final step writes table[n] now; take it as the answer.
        res <= sum;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: hold while stalled, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pyramid_count <= res;
    end
  end

  ipc_table #(
    .MAX_N(MAX_N)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .clr_addr (idx),
    .rd_hi    (rd_hi),
    .rd_lo    (rd_lo),
    .sum      (sum),
    .sum_valid(sum_valid)
  );

`include "integer_partition_counter_unit_assert.svh"

  // Step indices stay inside the current row of the sweep.
  `IPC_ASSERT_NOW(a_run_bounds, state == S_RUN, (k_cnt <= m_cnt) && (m_cnt <= n_reg))
  // The clear pointer never passes the requested count.
  `IPC_ASSERT_NOW(a_clear_bounds, state == S_CLEAR, idx <= n_reg)
  // The last step's write is in flight when the sequencer drains.
  `IPC_ASSERT_NOW(a_drain_write, state == S_DRAIN, sum_valid && !ctrl.rd)
  // A zero count skips the table and answers zero.
  `IPC_ASSERT_NEXT(a_zero_count, accept && (cube_count == 8'd0),
                   (state == S_FINISH) && (res == '0))

endmodule
